// ===== sv/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

    // Built number of entries.
    localparam int DEPTH = 16;

    // Entry index and rank width, and the width of a count from 0 to DEPTH.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Width of the capacity register.
    localparam int CAP_W = 5;

    // Command codes.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Each request beat is a get or a set; each one yields exactly one response
// beat. A get hit returns the stored value with found set and makes the
// entry the most recent one; a get miss returns found clear and zero. A set
// on a present key replaces its value, returns found set and makes it most
// recent; otherwise it inserts the pair, taking a free slot while the
// occupied count is below the capacity and the least recent entry after
// that. A set always returns a read value of zero, and with a capacity of
// zero a set is ignored. The capacity register resets to 16, and the
// capacity in effect saturates at the built depth; lowering it drops no
// entries. It may only be written while no request is in flight. A request
// beat is captured first; then all keys are compared in parallel and the
// recency ranks, the key registers and the value memory are updated
// together. The response is then registered from the value memory read
// port, overlapping with the capture of the next request, so the block can
// take a new request before the previous response has left, as long as
// responses are taken. There is no clearing pass after reset.
module lru_key_value_cache (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       req_valid,
    output logic                      req_stall,
    input  wire lkvc_pkg::cmd_item_t  req,
    output logic                      rsp_valid,
    input  wire                       rsp_stall,
    output lkvc_pkg::result_t         rsp,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire [lkvc_pkg::CAP_W-1:0] cfg_capacity
);

    import lkvc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0]       state_reg, state_next;
    cmd_item_t        item_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rank_reg [DEPTH];
    logic [31:0]      keys_reg [DEPTH];
    logic [31:0]      values_mem [DEPTH];
    logic [31:0]      rdata_reg;
    logic             found_reg;
    logic             get_reg;
    logic             rsp_valid_reg;
    result_t          rsp_reg;

    logic             req_accept;
    logic             rsp_load;
    logic [DEPTH-1:0] valid_vec;
    logic [DEPTH-1:0] hit_vec;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] victim_idx;
    logic [CNT_W-1:0] cap_eff;
    logic             is_get;
    logic             do_set;
    logic             do_update;
    logic             do_insert;
    logic             do_evict;
    logic             do_rank;
    logic [IDX_W-1:0] target_idx;
    logic [CNT_W-1:0] threshold;

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A new request may be captured while the previous response is being
    // registered, as long as the response register is free or drains now.
    assign req_stall  = (state_reg == ST_LOOK) ||
                        (state_reg == ST_RESP && rsp_valid_reg && rsp_stall);
    assign req_accept = req_valid && !req_stall;
    assign rsp_load   = (state_reg == ST_RESP) && (!rsp_valid_reg || !rsp_stall);

    // Effective capacity saturates at the built depth.
    always_comb
    begin
        if (32'(capacity_reg) > 32'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(capacity_reg);
        end
    end

    // Parallel key compare over the occupied entries, and the search for
    // the least recent entry. Keys are unique, so at most one entry hits.
    always_comb
    begin
        hit_idx    = '0;
        victim_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = CNT_W'(i) < count_reg;
            hit_vec[i]   = valid_vec[i] && (keys_reg[i] == item_reg.key);
            if (valid_vec[i] && CNT_W'(rank_reg[i]) == count_reg - CNT_W'(1))
            begin
                victim_idx = IDX_W'(i);
            end
        end
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit       = |hit_vec;
    assign is_get    = item_reg.command == CMD_GET;
    assign do_set    = (state_reg == ST_LOOK) && !is_get && (cap_eff != '0);
    assign do_update = do_set && hit;
    assign do_insert = do_set && !hit && (count_reg < cap_eff);
    assign do_evict  = do_set && !hit && !(count_reg < cap_eff);
    assign do_rank   = ((state_reg == ST_LOOK) && is_get && hit) || do_set;

    // Every rank below the threshold ages by one and the target becomes the
    // most recent. A fresh insert ages all occupied entries.
    always_comb
    begin
        target_idx = hit_idx;
        threshold  = CNT_W'(rank_reg[hit_idx]);
        count_next = count_reg;
        if (do_insert)
        begin
            target_idx = count_reg[IDX_W-1:0];
            threshold  = count_reg;
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_evict)
        begin
            target_idx = victim_idx;
            threshold  = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = req_accept ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_W'(16);
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_capacity;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (do_rank)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (IDX_W'(i) == target_idx)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_vec[i] && CNT_W'(rank_reg[i]) < threshold)
                    begin
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                    end
                end
            end
        end
    end

    // Payload registers, key registers and the value memory.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            item_reg <= req;
        end
        if (state_reg == ST_LOOK)
        begin
            found_reg <= hit && (is_get || cap_eff != '0);
            get_reg   <= is_get;
            if (is_get)
            begin
                rdata_reg <= values_mem[hit_idx];
            end
        end
        if (do_set)
        begin
            values_mem[target_idx] <= item_reg.value;
        end
        if (do_insert || do_evict)
        begin
            keys_reg[target_idx] <= item_reg.key;
        end
        if (rsp_load)
        begin
            rsp_reg.found      <= found_reg;
            rsp_reg.read_value <= (get_reg && found_reg) ? rdata_reg : '0;
        end
    end

    // The occupied count never exceeds the built depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
    else $error("occupied count exceeds depth");

    // Keys stay unique, so a lookup hits at most one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOK |-> $onehot0(hit_vec))
    else $error("key stored in more than one entry");

    // A held response keeps the block waiting with its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && rsp_valid_reg && rsp_stall) |=> state_reg == ST_RESP)
    else $error("result lost while response stalled");

    // The count grows only through an insert into a free slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(do_insert) && $past(rst_n)))
    else $error("occupied count changed without insert");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Testbench for lru_key_value_cache.
//
// Requests are driven as get and set beats. A scoreboard object keeps a
// cycle-free model of the cache (keys, values, recency ranks, occupied count
// and capacity). Each accepted request beat is run through that model, and
// the response it predicts is queued. Every accepted response beat is checked
// field by field against the oldest queued prediction.
//
// The run starts with a short directed sequence: a miss on an empty cache,
// sets and gets with extreme keys and values, an update of a present key,
// a capacity lowered below the occupied count, and a capacity of zero that
// must ignore both updates and inserts. The random part then runs through a
// series of capacity settings (zero, one, the built depth, values above it
// and random ones), each with a small pool of keys so that gets hit and sets
// both update and evict. The capacity register is only written once every
// predicted response has been taken.
module tb;

    import lkvc_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int RAND_PHASES     = 13;
    localparam int ITEMS_PER_PHASE = 142;
    localparam int DRAIN_CYCLES    = 8;

    // Predictor and store of predicted responses.
    class cache_scoreboard;
        logic [31:0] entry_key [DEPTH];
        logic [31:0] entry_value [DEPTH];
        int unsigned entry_rank [DEPTH];
        int unsigned used;
        int unsigned capacity;
        result_t     predicted[$];
        int unsigned errors;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_key[i]   = '0;
                entry_value[i] = '0;
                entry_rank[i]  = 0;
            end
            used     = 0;
            capacity = 16;
            errors   = 0;
        endfunction

        function int lookup(logic [31:0] key);
            for (int i = 0; i < used; i++)
            begin
                if (entry_key[i] == key)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Make an entry the most recent; the ones that were more recent age.
        function void promote(int unsigned idx);
            int unsigned old_rank;
            old_rank = entry_rank[idx];
            for (int i = 0; i < used; i++)
            begin
                if (entry_rank[i] < old_rank)
                begin
                    entry_rank[i]++;
                end
            end
            entry_rank[idx] = 0;
        endfunction

        function result_t apply_request(cmd_item_t item);
            result_t     res;
            int          hit;
            int unsigned limit;
            int unsigned victim;
            res   = '0;
            limit = (capacity > DEPTH) ? DEPTH : capacity;
            if (item.command == CMD_GET)
            begin
                hit = lookup(item.key);
                if (hit >= 0)
                begin
                    promote(hit);
                    res.found      = 1'b1;
                    res.read_value = entry_value[hit];
                end
            end
            else if (limit != 0)
            begin
                hit = lookup(item.key);
                if (hit >= 0)
                begin
                    promote(hit);
                    entry_value[hit] = item.value;
                    res.found        = 1'b1;
                end
                else if (used < limit)
                begin
                    for (int i = 0; i < used; i++)
                    begin
                        entry_rank[i]++;
                    end
                    entry_key[used]   = item.key;
                    entry_value[used] = item.value;
                    entry_rank[used]  = 0;
                    used++;
                end
                else
                begin
                    victim = 0;
                    for (int i = 0; i < used; i++)
                    begin
                        if (entry_rank[i] == used - 1)
                        begin
                            victim = i;
                        end
                    end
                    entry_key[victim]   = item.key;
                    entry_value[victim] = item.value;
                    promote(victim);
                end
            end
            return res;
        endfunction

        function void note_request(cmd_item_t item);
            predicted.push_back(apply_request(item));
        endfunction

        function void check_response(result_t got);
            result_t want;
            if (predicted.size() == 0)
            begin
                $error("response beat arrived with no request outstanding");
                errors++;
                return;
            end
            want = predicted.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.read_value !== want.read_value)
            begin
                $error("read_value: expected %0d, got %0d",
                       want.read_value, got.read_value);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return predicted.size();
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              req_valid    = 1'b0;
    logic              req_stall;
    cmd_item_t         req          = '0;
    logic              rsp_valid;
    logic              rsp_stall    = 1'b0;
    result_t           rsp;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_capacity = '0;

    // Random idling on both sides is on while this is set; one phase in the
    // middle and the tail of the run clear it so the block also sees back-to-back traffic.
    bit                idle_en      = 1'b1;
    int                quiet_cycles = 0;
    logic [31:0]       key_pool[$];

    cache_scoreboard   sb = new();

    lru_key_value_cache dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drive one request beat and hold it until the block takes it. Values
    // read right after the edge are the ones the block saw at that edge.
    task automatic send_request(input cmd_item_t item);
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        sb.note_request(item);
    endtask

    // After a beat is taken, sometimes leave the request side idle for a
    // burst so that gaps land in either step of the block's work.
    task automatic maybe_pause_request();
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_directed(input logic cmd, input logic [31:0] key,
                                 input logic [31:0] value);
        cmd_item_t item;
        item.command = cmd;
        item.key     = key;
        item.value   = value;
        send_request(item);
        maybe_pause_request();
    endtask

    // The capacity may only change while nothing is in flight, so wait for
    // every predicted response to be taken first.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        while (sb.outstanding() != 0) @(posedge clk);
        cfg_capacity <= cap;
        cfg_valid    <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.capacity = cap;
        cfg_valid  <= 1'b0;
    endtask

    // Mostly keys from the current pool so that gets hit and sets update or
    // evict; now and then a fully random key.
    function automatic cmd_item_t random_request();
        cmd_item_t item;
        item.command = ($urandom_range(0, 1) != 0) ? CMD_SET : CMD_GET;
        if (key_pool.size() != 0 && $urandom_range(0, 7) != 0)
        begin
            item.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        else
        begin
            item.key = $urandom;
        end
        item.value = $urandom;
        return item;
    endfunction

    // Response side: stall in random bursts, with runs of no stall between.
    always
    begin
        @(posedge clk);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clk);
            rsp_stall <= 1'b0;
        end
        else
        begin
            repeat ($urandom_range(0, 10)) @(posedge clk);
        end
    end

    // Every response beat taken is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
        begin
            sb.check_response(rsp);
        end
    end

    // Watchdog: the run ends if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] prev_pool[$];
        int unsigned phase_caps [RAND_PHASES];
        int unsigned cap;
        int unsigned span;
        int          pool_size;

        phase_caps = '{16, 1, 31, 0, 4, 16, 2, 17, 31, 9, 0, 16, 16};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first at the capacity left by reset: a miss on an
        // empty cache, extreme keys and values, hits, and an update.
        send_directed(CMD_GET, 32'h0000_0000, 32'h1234_5678);
        send_directed(CMD_SET, 32'h8000_0000, 32'h7fff_ffff);
        send_directed(CMD_SET, 32'h7fff_ffff, 32'h8000_0000);
        send_directed(CMD_SET, 32'h0000_0000, 32'hffff_ffff);
        send_directed(CMD_SET, 32'hffff_ffff, 32'h0000_0000);
        send_directed(CMD_GET, 32'h8000_0000, 32'hffff_ffff);
        send_directed(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
        send_directed(CMD_GET, 32'h0000_0005, 32'h0000_0000);
        send_directed(CMD_SET, 32'h0000_0000, 32'h0000_007b);
        send_directed(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        req_valid <= 1'b0;

        // Capacity lowered below the four entries held: nothing is dropped,
        // inserts overwrite the least recent entry and the count stays.
        write_capacity(2);
        send_directed(CMD_SET, 32'h0000_0064, 32'h0000_0001);
        send_directed(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
        send_directed(CMD_SET, 32'h0000_0065, 32'h0000_0002);
        send_directed(CMD_GET, 32'h0000_0064, 32'h0000_0000);
        req_valid <= 1'b0;

        // Capacity zero: sets are ignored even on a present key, gets still
        // find what is stored.
        write_capacity(0);
        send_directed(CMD_SET, 32'h0000_0064, 32'hdead_beef);
        send_directed(CMD_SET, 32'h0000_00c8, 32'h0000_0005);
        send_directed(CMD_GET, 32'h0000_0064, 32'h0000_0000);
        req_valid <= 1'b0;

        // Random part, one phase per capacity setting. One phase in the
        // middle and the last two run with no idling on either side.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            idle_en = (p != 5) && (p < RAND_PHASES - 2);
            cap = (p == 10) ? $urandom_range(0, 31) : phase_caps[p];
            write_capacity(cap[CAP_W-1:0]);

            // A new key pool sized to the capacity, reusing some old keys so
            // that entries kept from earlier phases are hit as well.
            span = (cap > DEPTH) ? DEPTH : cap;
            prev_pool = key_pool;
            key_pool.delete();
            pool_size = $urandom_range(2, span + 6);
            for (int i = 0; i < pool_size; i++)
            begin
                if (prev_pool.size() != 0 && $urandom_range(0, 2) == 0)
                begin
                    key_pool.push_back(prev_pool[$urandom_range(0, prev_pool.size() - 1)]);
                end
                else
                begin
                    key_pool.push_back($urandom);
                end
            end

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_request(random_request());
                maybe_pause_request();
            end
            req_valid <= 1'b0;
        end

        // Let every predicted response arrive, then watch a little longer
        // for any stray response beat.
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lkvc_pkg.sv
sv/lru_key_value_cache.sv
test/tb.sv
